[rtl/signed_divide_three_widths_defines.svh]
// Assertion macros for the signed divider.
// Included by the top level; no other dependencies.
`ifndef SIGNED_DIVIDE_THREE_WIDTHS_DEFINES_SVH
`define SIGNED_DIVIDE_THREE_WIDTHS_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SDTW_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sdtw assertion failed");
// next-cycle implication
`define SDTW_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sdtw assertion failed");
`else
`define SDTW_ASSERT_IMP(name, clk, rst, pre, post)
`define SDTW_ASSERT_NXT(name, clk, rst, pre, post)
`endif

`endif

[rtl/sdtw_pkg.sv]
// Shared types and constants of the signed three-width divider.
// No dependencies.
`default_nettype none

package sdtw_pkg;

   localparam int CMD_W  = 2;
   localparam int DVD_W  = 64;
   localparam int DSR_W  = 32;
   localparam int NSTEP  = DSR_W;   // one quotient bit per stage

   // operand width selects (any other code runs as dword)
   localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WORD = 2'd1;

   typedef enum logic [1:0] {
      FAULT_OK       = 2'd0,
      FAULT_DIVZERO  = 2'd1,
      FAULT_OVERFLOW = 2'd2
   } fault_type;

   // one word in flight through the divide array
   typedef struct packed {
      logic [DSR_W-1:0] rem;    // partial remainder
      logic [DSR_W-1:0] quo;    // low dividend bits, quotient shifts in below
      logic [DSR_W-1:0] dsr;    // divisor magnitude
      logic             dneg;
      logic             vneg;
      logic [CMD_W-1:0] cmd;
      logic             zero;   // divisor is zero
      logic             ovf;    // quotient needs more than 32 bits
   } stage_type;

   typedef struct packed {
      logic [DSR_W-1:0] quotient;
      logic [DSR_W-1:0] remainder;
      fault_type        fault;
   } result_type;

endpackage

`default_nettype wire

[rtl/sdtw_if.sv]
// Valid/ready channels of the signed divider: request and response words.
// Depends on sdtw_pkg.
`default_nettype none

interface sdtw_req_if import sdtw_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic signed [DVD_W-1:0] dividend;
   logic [DSR_W-1:0]        divisor;

   modport source (output valid, output cmd, output dividend, output divisor,
                   input ready);
   modport sink   (input valid, input cmd, input dividend, input divisor,
                   output ready);
endinterface

interface sdtw_rsp_if import sdtw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DSR_W-1:0] quotient;
   logic [DSR_W-1:0] remainder;
   logic [1:0]       fault;

   modport source (output valid, output quotient, output remainder, output fault,
                   input ready);
   modport sink   (input valid, input quotient, input remainder, input fault,
                   output ready);
endinterface

`default_nettype wire

[rtl/signed_divide_three_widths.sv]
// Signed divide, 16/8, 32/16 or 64/32 by cmd, as a fully pipelined restoring
// divider. One word is accepted every cycle while the skid register is empty;
// each result passes one entry stage that takes operand magnitudes, 32 stages
// of the divide array that each settle one quotient bit with a 33-bit
// subtract, and the output register that applies signs, width masks and fault
// checks.
// A skid register behind the output lets the pipe keep moving after the
// consumer stalls until a word lands in it; the request side is ready while
// it is empty and reset is low.
// Zero divisor gives fault 1 and an out-of-range quotient gives fault 2,
// both with zero quotient and remainder.
// Depends on sdtw_pkg, sdtw_if.sv and signed_divide_three_widths_defines.svh.
`default_nettype none
`include "signed_divide_three_widths_defines.svh"

module signed_divide_three_widths import sdtw_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   sdtw_req_if.sink   req_bus,
   sdtw_rsp_if.source rsp_bus
);

   stage_type        stage_ff [0:NSTEP];
   stage_type        stage_in [0:NSTEP];
   logic [NSTEP:0]   valid_ff;
   logic             pipe_en;

   logic [DVD_W-1:0] dext;
   logic [DSR_W-1:0] vext;
   logic [DVD_W-1:0] dmag;
   logic [DSR_W-1:0] vmag;

   stage_type        fin;
   logic             fin_valid;
   logic             qneg;
   logic [DSR_W-1:0] limit;
   logic [DSR_W-1:0] wmask;
   logic             too_big;
   result_type       fin_res;

   result_type       out_ff;
   logic             out_valid_ff;
   result_type       skid_ff;
   logic             skid_valid_ff;

   // pipe moves whenever the skid register is free
   assign pipe_en       = !skid_valid_ff;
   assign req_bus.ready = pipe_en && !reset;

   // entry: sign-extend the selected width and take magnitudes
   always_comb begin
      case (req_bus.cmd)
         CMD_BYTE: begin
            dext = {{(DVD_W-16){req_bus.dividend[15]}}, req_bus.dividend[15:0]};
            vext = {{(DSR_W-8){req_bus.divisor[7]}}, req_bus.divisor[7:0]};
         end
         CMD_WORD: begin
            dext = {{(DVD_W-32){req_bus.dividend[31]}}, req_bus.dividend[31:0]};
            vext = {{(DSR_W-16){req_bus.divisor[15]}}, req_bus.divisor[15:0]};
         end
         default: begin
            dext = req_bus.dividend;
            vext = req_bus.divisor;
         end
      endcase
      dmag = dext[DVD_W-1] ? (~dext + DVD_W'(1)) : dext;
      vmag = vext[DSR_W-1] ? (~vext + DSR_W'(1)) : vext;

      stage_in[0].rem  = dmag[DVD_W-1:DSR_W];
      stage_in[0].quo  = dmag[DSR_W-1:0];
      stage_in[0].dsr  = vmag;
      stage_in[0].dneg = dext[DVD_W-1];
      stage_in[0].vneg = vext[DSR_W-1];
      stage_in[0].cmd  = req_bus.cmd;
      stage_in[0].zero = (vmag == '0);
      stage_in[0].ovf  = 1'b0;
   end

   // divide array: one restoring step per stage
   for (genvar gi = 1; gi <= NSTEP; gi++) begin : g_step
      logic [DSR_W:0] trial;
      logic           take;

      always_comb begin
         trial = {stage_ff[gi-1].rem, stage_ff[gi-1].quo[DSR_W-1]};
         take  = (trial >= {1'b0, stage_ff[gi-1].dsr});
         stage_in[gi]     = stage_ff[gi-1];
         stage_in[gi].rem = take ? DSR_W'(trial - {1'b0, stage_ff[gi-1].dsr})
                                 : trial[DSR_W-1:0];
         stage_in[gi].quo = {stage_ff[gi-1].quo[DSR_W-2:0], take};
         // high dividend half not below divisor: quotient exceeds 32 bits
         if (gi == 1) begin
            stage_in[gi].ovf = (stage_ff[gi-1].rem >= stage_ff[gi-1].dsr);
         end
      end
   end

   // pipeline registers, valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[NSTEP-1:0], req_bus.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k <= NSTEP; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // finish: zero and range checks, signs and width mask
   assign fin       = stage_ff[NSTEP];
   assign fin_valid = valid_ff[NSTEP];

   always_comb begin
      qneg = fin.dneg ^ fin.vneg;
      case (fin.cmd)
         CMD_BYTE: begin
            limit = DSR_W'(32'h0000_0080);
            wmask = DSR_W'(32'h0000_00ff);
         end
         CMD_WORD: begin
            limit = DSR_W'(32'h0000_8000);
            wmask = DSR_W'(32'h0000_ffff);
         end
         default: begin
            limit = DSR_W'(32'h8000_0000);
            wmask = DSR_W'(32'hffff_ffff);
         end
      endcase
      too_big = fin.ovf || (qneg ? (fin.quo > limit) : (fin.quo >= limit));

      if (fin.zero) begin
         fin_res.quotient  = '0;
         fin_res.remainder = '0;
         fin_res.fault     = FAULT_DIVZERO;
      end else if (too_big) begin
         fin_res.quotient  = '0;
         fin_res.remainder = '0;
         fin_res.fault     = FAULT_OVERFLOW;
      end else begin
         fin_res.quotient  = (qneg ? (~fin.quo + DSR_W'(1)) : fin.quo) & wmask;
         fin_res.remainder = (fin.dneg ? (~fin.rem + DSR_W'(1)) : fin.rem) & wmask;
         fin_res.fault     = FAULT_OK;
      end
   end

   // output register with skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && !rsp_bus.ready) begin
         if (pipe_en && fin_valid) begin
            skid_valid_ff <= 1'b1;
            skid_ff       <= fin_res;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         out_ff        <= skid_ff;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= pipe_en && fin_valid;
         out_ff        <= fin_res;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.quotient  = out_ff.quotient;
   assign rsp_bus.remainder = out_ff.remainder;
   assign rsp_bus.fault     = out_ff.fault;

   // checks
   `SDTW_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `SDTW_ASSERT_IMP(a_fault_zeroes, clock, reset, out_valid_ff && (out_ff.fault != FAULT_OK), (out_ff.quotient == '0) && (out_ff.remainder == '0))
   `SDTW_ASSERT_NXT(a_stall_holds, clock, reset, !pipe_en, $stable(valid_ff) && $stable(stage_ff[NSTEP]))

endmodule

`default_nettype wire

[sim/tb_signed_divide_three_widths.sv]
// Self-checking bench for the three-width signed divider (16/8, 32/16, 64/32).
// Drives request words from a queue, predicts each result and compares them in order.
// Depends on sdtw_pkg, sdtw_if.sv and the signed_divide_three_widths top level.
`timescale 1ns / 100ps

module tb_signed_divide_three_widths;
   import sdtw_pkg::*;

   localparam logic [CMD_W-1:0] CMD_DWORD = 2'd2;
   localparam logic [CMD_W-1:0] CMD_ALIAS = 2'd3;   // unused code, runs as dword
   localparam int RANDOM_WORDS  = 750;
   localparam int HOLD_CYCLES   = 200;
   localparam int HOLD_AFTER    = 150;
   localparam int DRAIN_CYCLES  = 40;
   localparam int STALL_LIMIT   = 4000;
   localparam int REPORT_MAX    = 10;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [DVD_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_word_type;

   logic clock;
   logic reset;

   sdtw_req_if req_bus ();
   sdtw_rsp_if rsp_bus ();

   signed_divide_three_widths dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   div_word_type div_stimulus[$];
   result_type   results_due[$];
   int           stim_total;
   int           words_sent;
   int           results_seen;
   int           mismatch_count;
   int           idle_cycles;

   // sender burst state
   div_word_type next_word;
   int           burst_left = 1;
   int           gap_left = 0;

   // receiver stall state
   logic [31:0] ready_pattern;
   logic [4:0]  pattern_pos = '0;
   int          hold_left = 0;
   bit          hold_done = 0;
   result_type  want;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // expected quotient, remainder and fault of one request word
   function automatic result_type idiv_predict(input logic [CMD_W-1:0] cmd,
                                               input logic [DVD_W-1:0] dvd,
                                               input logic [DSR_W-1:0] dsr);
      int unsigned w;
      logic [63:0] wmask, dmask, dlow, vlow, dmag, vmag, quo, rem, lim;
      logic        dneg, vneg, qneg;
      result_type  res;
      case (cmd)
         CMD_BYTE: w = 8;
         CMD_WORD: w = 16;
         default:  w = 32;
      endcase
      wmask = (64'd1 << w) - 64'd1;
      dmask = (w == 32) ? '1 : (64'd1 << (2 * w)) - 64'd1;
      dlow  = dvd & dmask;
      vlow  = {32'd0, dsr} & wmask;
      dneg  = dlow[2 * w - 1];
      vneg  = vlow[w - 1];
      dmag  = dneg ? (~dlow + 64'd1) & dmask : dlow;
      vmag  = vneg ? (~vlow + 64'd1) & wmask : vlow;
      res.quotient  = '0;
      res.remainder = '0;
      res.fault     = FAULT_OK;
      if (vmag == 64'd0) begin
         res.fault = FAULT_DIVZERO;
      end else begin
         quo  = dmag / vmag;
         rem  = dmag % vmag;
         qneg = dneg ^ vneg;
         lim  = 64'd1 << (w - 1);
         if ((qneg && quo > lim) || (!qneg && quo >= lim)) begin
            res.fault = FAULT_OVERFLOW;
         end else begin
            if (qneg) quo = ~quo + 64'd1;
            if (dneg) rem = ~rem + 64'd1;
            res.quotient  = quo[31:0] & wmask[31:0];
            res.remainder = rem[31:0] & wmask[31:0];
         end
      end
      return res;
   endfunction

   function automatic div_word_type make_word(input logic [CMD_W-1:0] cmd,
                                              input logic [DVD_W-1:0] dvd,
                                              input logic [DSR_W-1:0] dsr);
      div_word_type item;
      item.cmd      = cmd;
      item.dividend = dvd;
      item.divisor  = dsr;
      return item;
   endfunction

   function automatic void flag_mismatch();
      mismatch_count++;
   endfunction

   // stimulus, reset and end of run
   initial begin
      int unsigned        w;
      int                 kind;
      logic [CMD_W-1:0]   cmd;
      logic [63:0]        wmask, dmask, junk_d, absv, r_mag, dlow;
      logic [31:0]        junk_v, vlow;
      logic signed [63:0] lim, q, v, prod, d;
      bit                 neg_r;
      div_word_type       item;

      req_bus.valid    = 1'b0;
      req_bus.cmd      = '0;
      req_bus.dividend = '0;
      req_bus.divisor  = '0;
      rsp_bus.ready    = 1'b0;
      reset            = 1'b1;

      // directed words: signs, width limits, faults, ignored high bits
      div_stimulus.push_back(make_word(CMD_BYTE, 64'd100, 32'h07));
      div_stimulus.push_back(make_word(CMD_BYTE, 64'hFFFF_FFFF_FFFF_FF9C, 32'h07));
      div_stimulus.push_back(make_word(CMD_BYTE, 64'd100, 32'hF9));
      div_stimulus.push_back(make_word(CMD_BYTE, 64'hFFFF_FFFF_FFFF_FF9C, 32'hF9));
      div_stimulus.push_back(make_word(CMD_BYTE, 64'h0000_0000_0000_8000, 32'hFF));
      div_stimulus.push_back(make_word(CMD_BYTE, 64'd127, 32'h01));
      div_stimulus.push_back(make_word(CMD_BYTE, 64'd128, 32'h01));
      div_stimulus.push_back(make_word(CMD_BYTE, 64'h0000_0000_0000_FF80, 32'h01));
      div_stimulus.push_back(make_word(CMD_BYTE, 64'h0000_0000_0000_FF7F, 32'h01));
      div_stimulus.push_back(make_word(CMD_BYTE, 64'd1234, 32'hABCD_EF00));
      div_stimulus.push_back(make_word(CMD_BYTE, 64'h1234_5678_9ABC_0064, 32'h07));
      div_stimulus.push_back(make_word(CMD_BYTE, 64'd100, 32'hFFFF_FF07));
      div_stimulus.push_back(make_word(CMD_BYTE, 64'd0, 32'hFF));
      div_stimulus.push_back(make_word(CMD_WORD, 64'h0000_0000_8000_0000, 32'h0000_FFFF));
      div_stimulus.push_back(make_word(CMD_WORD, 64'h0000_0000_0001_0000, 32'h0000_0002));
      div_stimulus.push_back(make_word(CMD_WORD, 64'hFFFF_FFFF_FFFF_0000, 32'h0000_0002));
      div_stimulus.push_back(make_word(CMD_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_FFFF));
      div_stimulus.push_back(make_word(CMD_DWORD, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF));
      div_stimulus.push_back(make_word(CMD_DWORD, 64'h3FFF_FFFF_8000_0000, 32'h7FFF_FFFF));
      div_stimulus.push_back(make_word(CMD_DWORD, 64'hC000_0000_0000_0000, 32'h8000_0000));
      div_stimulus.push_back(make_word(CMD_DWORD, 64'h4000_0000_0000_0000, 32'h8000_0000));
      div_stimulus.push_back(make_word(CMD_DWORD, 64'd0, 32'd0));
      div_stimulus.push_back(make_word(CMD_DWORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
      div_stimulus.push_back(make_word(CMD_ALIAS, 64'hFFFF_FFFF_FFF0_BDC0, 32'h0000_0003));
      div_stimulus.push_back(make_word(CMD_ALIAS, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0));

      // random words, mostly built from a chosen quotient and remainder
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         kind   = $urandom_range(0, 19);
         cmd    = ($urandom_range(0, 7) == 0) ? CMD_ALIAS : CMD_W'($urandom_range(0, 2));
         w      = (cmd == CMD_BYTE) ? 8 : (cmd == CMD_WORD) ? 16 : 32;
         wmask  = (64'd1 << w) - 64'd1;
         dmask  = (w == 32) ? '1 : (64'd1 << (2 * w)) - 64'd1;
         lim    = 64'sd1 <<< (w - 1);
         junk_d = {$urandom, $urandom};
         junk_v = $urandom;
         if (kind < 14) begin
            if ($urandom_range(0, 15) == 0) begin
               v = -lim;
            end else begin
               v = {$urandom, $urandom} & ((64'd1 << $urandom_range(1, w - 1)) - 64'd1);
               if (v == 0) v = 1;
               if ($urandom_range(0, 1) == 1) v = -v;
            end
            case ($urandom_range(0, 15))
               0: q = lim - 1;
               1: q = -lim;
               2: q = lim;          // one past the top: overflow
               3: q = -lim - 1;     // one past the bottom: overflow
               default: begin
                  q = {$urandom, $urandom} & ((64'd1 << $urandom_range(0, w - 1)) - 64'd1);
                  if ($urandom_range(0, 1) == 1) q = -q;
               end
            endcase
            prod  = q * v;
            absv  = (v < 0) ? -v : v;
            r_mag = {$urandom, $urandom} % absv;
            neg_r = (prod < 0) || (prod == 0 && $urandom_range(0, 1) == 1);
            d     = neg_r ? prod - r_mag : prod + r_mag;
            item.dividend = (junk_d & ~dmask) | (d & dmask);
            item.divisor  = (junk_v & ~wmask[31:0]) | (v[31:0] & wmask[31:0]);
         end else if (kind < 16) begin
            // zero divisor, junk above the used bits
            item.dividend = junk_d;
            item.divisor  = junk_v & ~wmask[31:0];
         end else if (kind < 18) begin
            item.dividend = junk_d;
            item.divisor  = junk_v;
         end else begin
            // corner operands
            case ($urandom_range(0, 3))
               0: dlow = 64'd1 << (2 * w - 1);
               1: dlow = (64'd1 << (2 * w - 1)) - 64'd1;
               2: dlow = 64'd0;
               default: dlow = dmask;
            endcase
            case ($urandom_range(0, 3))
               0: vlow = 32'd1;
               1: vlow = wmask[31:0];
               2: vlow = lim[31:0];
               default: vlow = lim[31:0] - 32'd1;
            endcase
            item.dividend = (junk_d & ~dmask) | (dlow & dmask);
            item.divisor  = (junk_v & ~wmask[31:0]) | (vlow & wmask[31:0]);
         end
         item.cmd = cmd;
         div_stimulus.push_back(item);
      end
      stim_total = div_stimulus.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (words_sent != stim_total || results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_signed_divide_three_widths: done, clean");
      end else begin
         $display("tb_signed_divide_three_widths: done, errors");
      end
      $finish;
   end

   // request driver: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            results_due.push_back(idiv_predict(req_bus.cmd, req_bus.dividend,
                                               req_bus.divisor));
            words_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0 || div_stimulus.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_bus.valid <= 1'b0;
            end else begin
               next_word = div_stimulus.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.cmd      <= next_word.cmd;
               req_bus.dividend <= next_word.dividend;
               req_bus.divisor  <= next_word.divisor;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
         end
      end
   end

   // response ready: one long hold-off, otherwise a rolling stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (pattern_pos == 5'd0) begin
            case ($urandom_range(0, 3))
               0: ready_pattern = '1;
               1: ready_pattern = $urandom;
               default: ready_pattern = $urandom | $urandom;
            endcase
         end
         rsp_bus.ready <= ready_pattern[pattern_pos];
         pattern_pos = pattern_pos + 5'd1;
      end
   end

   // response monitor: in-order compare against predicted results
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (results_due.size() == 0) begin
            if (mismatch_count < REPORT_MAX)
               $display("unexpected result word: q=%h r=%h fault=%0d",
                        rsp_bus.quotient, rsp_bus.remainder, rsp_bus.fault);
            flag_mismatch();
         end else begin
            want = results_due.pop_front();
            if (rsp_bus.quotient !== want.quotient || rsp_bus.remainder !== want.remainder ||
                rsp_bus.fault !== want.fault) begin
               if (mismatch_count < REPORT_MAX)
                  $display("result %0d: expected q=%h r=%h fault=%0d, got q=%h r=%h fault=%0d",
                           results_seen - 1, want.quotient, want.remainder, want.fault,
                           rsp_bus.quotient, rsp_bus.remainder, rsp_bus.fault);
               flag_mismatch();
            end
         end
      end
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles == STALL_LIMIT) begin
               $display("tb_signed_divide_three_widths: done, errors");
               $finish;
            end
         end
      end
   end

endmodule
